### sv/srs_pkg.sv
// Shared types and constants for the servo recipe sequencer.
// Used by srs_store, srs_lane, servo_recipe_sequencer_unit and srs_check.
// No dependencies.
`default_nettype none

package srs_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_SPARE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OPC_END     = 3'd0,
    OPC_MOVE    = 3'd1,
    OPC_WAIT    = 3'd2,
    OPC_DMOVE   = 3'd3,
    OPC_LOOP    = 3'd4,
    OPC_ENDLOOP = 3'd5,
    OPC_DELAY   = 3'd6,
    OPC_NOP     = 3'd7
  } opcode_t;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_PARAM = 2'd1;
  localparam logic [1:0] FAULT_NEST  = 2'd2;

  localparam int WORD_W  = 8;
  localparam int PARAM_W = 5;
  localparam int ADDR_IN_W = 5;

  localparam logic [PARAM_W-1:0] MOVE_MAX  = 5'd5;
  localparam logic [PARAM_W-1:0] DMOVE_MAX = 5'd3;
  localparam logic signed [7:0]  LOOP_MIN  = 8'sh80;

  typedef struct packed {
    op_t                 operation;
    logic                channel;
    logic [ADDR_IN_W-1:0] address;
    logic [WORD_W-1:0]   instruction;
    logic [1:0]          running;
  } req_t;

  typedef struct packed {
    logic       move_valid_a;
    logic [2:0] position_a;
    logic       move_valid_b;
    logic [2:0] position_b;
    logic [1:0] fault_a;
    logic [1:0] fault_b;
    logic       ended_a;
    logic       ended_b;
    logic       red_led;
    logic       green_led;
  } rsp_t;

  // Per-lane control from the pipeline
  typedef struct packed {
    logic tick;
    logic run;
    logic restart;
  } lane_ctrl_t;

  // Per-lane result of the step being retired
  typedef struct packed {
    logic       move_valid;
    logic [2:0] position;
    logic [1:0] fault;
    logic       ended;
  } lane_res_t;

endpackage

`default_nettype wire

### sv/servo_recipe_sequencer_unit.sv
// Servo recipe sequencer top level: request stage, recipe store, lanes and
// response register. Depends on srs_pkg, srs_store and srs_lane.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one word: a tick, a recipe
//   write or a lane restart. rsp channel (rsp_valid/rsp_stall/rsp) returns
//   exactly one word for every request: moves for a tick, plus the fault and
//   end flags of both lanes and the two LEDs.
//   Timing: the accepting edge registers the request and reads the recipe
//   store at each lane's program counter; when the request stage advances,
//   both lanes execute and the response register and rsp_valid are loaded.
//   Throughput: a write is taken every cycle while rsp is not stalled; a tick
//   or restart holds off further requests until it leaves the request stage,
//   since the next fetch needs the program counters it leaves.
//   Reset: lane state clears at once; the store is then swept to end words
//   at all 2**clog2(RECIPE_DEPTH) addresses with req_stall high.
//   While rsp is stalled the response holds and one more request may wait in
//   the request stage; req_stall rises behind it.
`default_nettype none

module servo_recipe_sequencer_unit #(
  parameter int RECIPE_DEPTH = 32,
  parameter int CHANNELS     = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire srs_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output srs_pkg::rsp_t      rsp
);

  localparam int AW    = $clog2(RECIPE_DEPTH);
  localparam int LANES = (CHANNELS > 1) ? 2 : 1;
  localparam int NADDR = 2**srs_pkg::ADDR_IN_W;

  // write address folded onto the recipe depth
  function automatic logic [NADDR*AW-1:0] mod_table();
    logic [NADDR*AW-1:0] tbl;
    int                  r;
    tbl = '0;
    r   = 0;
    for (int i = 0; i < NADDR; i++) begin
      tbl[i*AW +: AW] = AW'(r);
      r = (r == RECIPE_DEPTH - 1) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam logic [NADDR*AW-1:0] ADDR_MOD = mod_table();

  logic                                accept;
  logic                                busy;
  logic                                s1_valid;
  srs_pkg::req_t                       s1;
  logic                                s1_adv;
  logic                                s1_blocks;
  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  logic [LANES-1:0][AW-1:0]            lane_pc;
  logic [LANES-1:0][srs_pkg::WORD_W-1:0] lane_word;
  srs_pkg::lane_ctrl_t                 lane_ctrl [LANES];
  srs_pkg::lane_res_t                  lane_res [LANES];
  srs_pkg::lane_res_t                  res_a, res_b;
  srs_pkg::rsp_t                       rsp_next;

  // hold new work while a tick or restart still owns the lane state
  assign s1_blocks = s1_valid && ((s1.operation == srs_pkg::OP_TICK) ||
                                  (s1.operation == srs_pkg::OP_RESTART));
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = busy || s1_blocks || (s1_valid && !s1_adv);
  assign accept    = req_valid && !req_stall;

  assign wr_en   = accept && (req.operation == srs_pkg::OP_WRITE) &&
                   ((LANES > 1) || (req.channel == 1'b0));
  assign wr_addr = ADDR_MOD[req.address*AW +: AW];

  srs_store #(
    .RECIPE_DEPTH (RECIPE_DEPTH),
    .LANES        (LANES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_lane (req.channel),
    .wr_addr (wr_addr),
    .wr_data (req.instruction),
    .rd_en   (accept),
    .rd_addr (lane_pc),
    .rd_word (lane_word),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_comb begin
      lane_ctrl[l].tick    = s1_adv && (s1.operation == srs_pkg::OP_TICK);
      lane_ctrl[l].run     = s1.running[l];
      lane_ctrl[l].restart = s1_adv && (s1.operation == srs_pkg::OP_RESTART) &&
                             (s1.channel == 1'(l));
    end

    srs_lane #(
      .RECIPE_DEPTH (RECIPE_DEPTH)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl[l]),
      .word (lane_word[l]),
      .pc   (lane_pc[l]),
      .res  (lane_res[l])
    );
  end

  assign res_a = lane_res[0];
  assign res_b = (LANES > 1) ? lane_res[LANES-1] : '0;

  always_comb begin
    rsp_next              = '0;
    rsp_next.move_valid_a = res_a.move_valid;
    rsp_next.position_a   = res_a.position;
    rsp_next.move_valid_b = res_b.move_valid;
    rsp_next.position_b   = res_b.position;
    rsp_next.fault_a      = res_a.fault;
    rsp_next.fault_b      = res_b.fault;
    rsp_next.ended_a      = res_a.ended;
    rsp_next.ended_b      = res_b.ended;
    rsp_next.red_led      = (res_a.fault != srs_pkg::FAULT_NONE);
    rsp_next.green_led    = (res_a.fault == srs_pkg::FAULT_NEST) ||
                            ((res_a.fault == srs_pkg::FAULT_NONE) && s1.running[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### sv/srs_store.sv
// Recipe store: one bank per lane, one write and one registered read each.
// Swept to end words after reset. Depends on srs_pkg.
`default_nettype none

module srs_store #(
  parameter int RECIPE_DEPTH = 32,
  parameter int LANES        = 2
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     wr_en,
  input  wire logic                                     wr_lane,
  input  wire logic [$clog2(RECIPE_DEPTH)-1:0]          wr_addr,
  input  wire logic [srs_pkg::WORD_W-1:0]               wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [LANES-1:0][$clog2(RECIPE_DEPTH)-1:0] rd_addr,
  output logic      [LANES-1:0][srs_pkg::WORD_W-1:0]    rd_word,
  output logic                                          busy
);

  localparam int AW = $clog2(RECIPE_DEPTH);

  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_bank
    logic [srs_pkg::WORD_W-1:0] bank [2**AW];
    logic                       we;
    logic [AW-1:0]              wa;
    logic [srs_pkg::WORD_W-1:0] wd;

    always_comb begin
      we = busy || (wr_en && (wr_lane == 1'(l)));
      wa = busy ? clr_addr : wr_addr;
      wd = busy ? '0 : wr_data;
    end

    always_ff @(posedge clk) begin
      if (we) begin
        bank[wa] <= wd;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_word[l] <= bank[rd_addr[l]];
      end
    end
  end

endmodule

`default_nettype wire

### sv/srs_lane.sv
// One servo lane: program counter, wait/delay counters, loop state and flags,
// plus the execute step for the fetched word. Depends on srs_pkg.
`default_nettype none

module srs_lane #(
  parameter int RECIPE_DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire srs_pkg::lane_ctrl_t                 ctrl,
  input  wire logic [srs_pkg::WORD_W-1:0]          word,
  output logic      [$clog2(RECIPE_DEPTH)-1:0]     pc,
  output srs_pkg::lane_res_t                       res
);

  localparam int AW = $clog2(RECIPE_DEPTH);

  logic [AW-1:0]         pc_next;
  logic [AW-1:0]         loop_ret, loop_ret_next;
  logic [4:0]            wait_cnt, wait_cnt_next;
  logic [4:0]            reload, reload_next;
  logic signed [7:0]     loop_rem, loop_rem_next;
  logic                  ended, ended_next;
  logic [1:0]            fault, fault_next;

  always_comb begin
    srs_pkg::opcode_t            opc;
    logic [srs_pkg::PARAM_W-1:0] param;
    logic                        fire;
    logic                        jump;
    logic signed [7:0]           dec;
    logic [AW-1:0]               base;

    opc           = srs_pkg::opcode_t'(word[7:5]);
    param         = word[srs_pkg::PARAM_W-1:0];
    fire          = ctrl.tick && ctrl.run && (wait_cnt == '0) && (fault == srs_pkg::FAULT_NONE);
    jump          = 1'b0;
    dec           = (loop_rem != srs_pkg::LOOP_MIN) ? loop_rem - 8'sd1 : loop_rem;
    base          = pc;
    pc_next       = pc;
    loop_ret_next = loop_ret;
    wait_cnt_next = wait_cnt;
    reload_next   = reload;
    loop_rem_next = loop_rem;
    ended_next    = ended;
    fault_next    = fault;
    res           = '0;

    if (fire) begin
      unique case (opc)
        srs_pkg::OPC_END: begin
          ended_next = 1'b1;
        end
        srs_pkg::OPC_MOVE: begin
          if (param > srs_pkg::MOVE_MAX) begin
            fault_next = srs_pkg::FAULT_PARAM;
          end else begin
            res.move_valid = 1'b1;
            res.position   = param[2:0];
          end
        end
        srs_pkg::OPC_WAIT: begin
          // only fires at a zero count, so the sum is the parameter
          wait_cnt_next = param;
        end
        srs_pkg::OPC_DMOVE: begin
          if (param > srs_pkg::DMOVE_MAX) begin
            fault_next = srs_pkg::FAULT_PARAM;
          end else begin
            res.move_valid = 1'b1;
            res.position   = {param[1:0], 1'b0};
          end
        end
        srs_pkg::OPC_LOOP: begin
          if (loop_rem != 8'sd0) begin
            fault_next = srs_pkg::FAULT_NEST;
          end
          loop_ret_next = pc;
          loop_rem_next = signed'({3'b000, param});
        end
        srs_pkg::OPC_ENDLOOP: begin
          loop_rem_next = dec;
          jump          = (dec > 8'sd0);
        end
        srs_pkg::OPC_DELAY: begin
          reload_next = param;
        end
        srs_pkg::OPC_NOP: begin
        end
        default: begin
        end
      endcase
      base = jump ? loop_ret : pc;
      if (ended_next) begin
        pc_next = base;
      end else begin
        pc_next = (base == AW'(RECIPE_DEPTH - 1)) ? '0 : base + 1'b1;
      end
    end

    // count down on every tick, reload at zero
    if (ctrl.tick) begin
      if (wait_cnt_next == '0) begin
        wait_cnt_next = reload_next;
      end else begin
        wait_cnt_next = wait_cnt_next - 1'b1;
      end
    end

    if (ctrl.restart) begin
      pc_next       = '0;
      loop_ret_next = '0;
      wait_cnt_next = '0;
      reload_next   = '0;
      loop_rem_next = '0;
      ended_next    = 1'b0;
      fault_next    = srs_pkg::FAULT_NONE;
    end

    res.fault = fault_next;
    res.ended = ended_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      loop_ret <= '0;
      wait_cnt <= '0;
      reload   <= '0;
      loop_rem <= '0;
      ended    <= 1'b0;
      fault    <= srs_pkg::FAULT_NONE;
    end else begin
      pc       <= pc_next;
      loop_ret <= loop_ret_next;
      wait_cnt <= wait_cnt_next;
      reload   <= reload_next;
      loop_rem <= loop_rem_next;
      ended    <= ended_next;
      fault    <= fault_next;
    end
  end

endmodule

`default_nettype wire

### sv/srs_check.sv
// Port-level checks for servo_recipe_sequencer_unit, bound to the top level.
// Depends on srs_pkg.
`default_nettype none

module srs_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire srs_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire srs_pkg::rsp_t rsp
);

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("response word changed while stalled");

  // a rising rsp_valid must trace back to an accepted request
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
    else $error("response without a matching request");

  // an accepted tick raises req_stall in the following cycle
  a_tick_gap: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req.operation == srs_pkg::OP_TICK)) |=> req_stall)
    else $error("request taken straight after a tick");

  // red LED mirrors a channel 0 fault, and idle channels report position zero
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.red_led == (rsp.fault_a != srs_pkg::FAULT_NONE)) &&
                   (rsp.move_valid_a || (rsp.position_a == 3'd0)) &&
                   (rsp.move_valid_b || (rsp.position_b == 3'd0))))
    else $error("inconsistent status in response word");

endmodule

bind servo_recipe_sequencer_unit srs_check u_srs_check (.*);

`default_nettype wire
